[hdl/i2cee_pkg.sv]
// Shared types and constants of the I2C EEPROM slave model.
`default_nettype none

package i2cee_pkg;

  localparam int DEV_ADDR_W   = 7;
  localparam int MEM_SIZE_W   = 13;
  localparam int PAGE_SIZE_W  = 7;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int BYTE_W       = 8;
  localparam int ADDR_PAIR_W  = 16;

  localparam logic [BYTE_W-1:0]      ERASED_BYTE     = 8'hFF;
  localparam logic [DEV_ADDR_W-1:0]  DEV_ADDR_RESET  = 7'd80;
  localparam logic [MEM_SIZE_W-1:0]  MEM_SIZE_RESET  = 13'd4096;
  localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RESET = 7'd64;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEM_SIZE       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_SIZE      = 2'd2;

  typedef enum logic [1:0] {
    ACT_MATCH = 2'd0,
    ACT_RX    = 2'd1,
    ACT_READ  = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MOD_SRC_ADDR,
    MOD_SRC_CUR,
    MOD_SRC_START
  } mod_src_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_MOD,
    ST_APPLY,
    ST_RDMEM,
    ST_COMMIT_RD,
    ST_COMMIT_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     load_item;
    logic     do_match;
    logic     latch_high;
    logic     buffer_byte;
    logic     mod_start;
    mod_src_t mod_src;
    logic     addr_set;
    logic     cur_inc;
    logic     read_issue;
    logic     capture_read;
    logic     commit_init;
    logic     commit_write;
    logic     stop_finish;
    logic     clear_step;
  } cmd_t;

  typedef struct packed {
    action_t    action;
    logic       active;
    logic [1:0] seen;
    logic       write_pending;
    logic       fill_zero;
    logic       commit_last;
    logic       mod_done;
    logic       clear_last;
  } status_t;

endpackage

`default_nettype wire

[hdl/i2cee_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module i2cee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/i2cee_mod.sv]
// Iterative restoring remainder unit, one dividend bit per cycle.
`default_nettype none

module i2cee_mod #(
  parameter int XW = 16,
  parameter int MW = 13
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [XW-1:0] x,
  input  wire logic [MW-1:0] m,
  output logic               done,
  output logic      [MW-1:0] rem
);

  localparam int CNTW = $clog2(XW);

  logic            run;
  logic [CNTW-1:0] cnt;
  logic [XW-1:0]   x_sh;
  logic [MW:0]     trial;
  logic [MW:0]     diff;

  assign trial = {rem, x_sh[XW-1]};
  assign diff  = trial - {1'b0, m};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(XW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_sh <= x;
      rem  <= '0;
    end else if (run) begin
      x_sh <= {x_sh[XW-2:0], 1'b0};
      // partial remainder stays below m, so the difference fits MW bits
      rem  <= (trial >= {1'b0, m}) ? diff[MW-1:0] : trial[MW-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/i2cee_dpath.sv]
// Datapath: config, transaction state, address arithmetic, page buffer and memory.
`default_nettype none

module i2cee_dpath #(
  parameter int MEM_DEPTH  = 4096,
  parameter int PAGE_DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [i2cee_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [i2cee_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic [1:0]                             action,
  input  wire logic [i2cee_pkg::DEV_ADDR_W-1:0]       target_address,
  input  wire logic                                   read_not_write,
  input  wire logic [i2cee_pkg::BYTE_W-1:0]           data_byte,
  input  wire i2cee_pkg::cmd_t                        cmd,
  output i2cee_pkg::status_t                          status,
  output logic      [i2cee_pkg::BYTE_W-1:0]           read_data,
  output logic                                        read_valid,
  output logic                                        selected
);

  localparam int AW   = $clog2(MEM_DEPTH);
  localparam int MW   = $clog2(MEM_DEPTH + 1);
  localparam int PW   = $clog2(PAGE_DEPTH + 1);
  localparam int PBW  = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;
  localparam int GW0  = (MW > i2cee_pkg::MEM_SIZE_W) ? MW : i2cee_pkg::MEM_SIZE_W;
  localparam int GW   = (PW > GW0) ? PW : GW0;
  localparam int XW   = i2cee_pkg::ADDR_PAIR_W;
  localparam int BW   = i2cee_pkg::BYTE_W;

  // configuration
  logic [i2cee_pkg::DEV_ADDR_W-1:0]  dev_addr;
  logic [i2cee_pkg::MEM_SIZE_W-1:0]  mem_size;
  logic [i2cee_pkg::PAGE_SIZE_W-1:0] page_lim;
  logic [MW-1:0]                     eff_m;
  logic [PW-1:0]                     eff_p;
  logic [GW-1:0]                     em_c;
  logic [GW-1:0]                     ep_c;

  // latched item
  i2cee_pkg::action_t                act;
  logic [i2cee_pkg::DEV_ADDR_W-1:0]  tgt;
  logic                              rnw;
  logic [BW-1:0]                     dbyte;

  // transaction state
  logic [AW-1:0] cur;
  logic [AW-1:0] start_addr;
  logic [PW-1:0] fill;
  logic [BW-1:0] high;
  logic [1:0]    seen;
  logic          pending;
  logic          active;

  // commit and clear sweeps
  logic [AW-1:0] wa;
  logic [PW-1:0] idx;
  logic [AW-1:0] clr_addr;

  logic [BW-1:0] res_data;
  logic          res_valid;

  // arithmetic
  logic [XW-1:0] mod_x;
  logic          mod_done;
  logic [MW-1:0] mod_rem;
  logic [AW-1:0] rem_a;
  logic [MW-1:0] rem_plus;
  logic [AW-1:0] rem_next;
  logic [MW-1:0] wa_plus;
  logic [AW-1:0] wa_next;
  logic          room;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [BW-1:0] mem_wdata;
  logic [BW-1:0] mem_rdata;
  logic          pb_we;
  logic [BW-1:0] pb_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr  <= i2cee_pkg::DEV_ADDR_RESET;
      mem_size  <= i2cee_pkg::MEM_SIZE_RESET;
      page_lim  <= i2cee_pkg::PAGE_SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        i2cee_pkg::CFG_DEVICE_ADDRESS: dev_addr  <= cfg_data[i2cee_pkg::DEV_ADDR_W-1:0];
        i2cee_pkg::CFG_MEM_SIZE:       mem_size  <= cfg_data[i2cee_pkg::MEM_SIZE_W-1:0];
        i2cee_pkg::CFG_PAGE_SIZE:      page_lim  <= cfg_data[i2cee_pkg::PAGE_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: clamp memory size to the array, page size to page and memory
  always_comb begin
    if (mem_size == '0) begin
      em_c = GW'(1);
    end else if (GW'(mem_size) > GW'(MEM_DEPTH)) begin
      em_c = GW'(MEM_DEPTH);
    end else begin
      em_c = GW'(mem_size);
    end
    ep_c = (page_lim == '0) ? GW'(1) : GW'(page_lim);
    if (ep_c > GW'(PAGE_DEPTH)) begin
      ep_c = GW'(PAGE_DEPTH);
    end
    if (ep_c > em_c) begin
      ep_c = em_c;
    end
  end

  always_ff @(posedge clk) begin
    eff_m <= em_c[MW-1:0];
    eff_p <= ep_c[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act   <= i2cee_pkg::action_t'(action);
      tgt   <= target_address;
      rnw   <= read_not_write;
      dbyte <= data_byte;
    end
  end

  always_comb begin
    unique case (cmd.mod_src)
      i2cee_pkg::MOD_SRC_ADDR:  mod_x = {high, dbyte};
      i2cee_pkg::MOD_SRC_CUR:   mod_x = XW'(cur);
      i2cee_pkg::MOD_SRC_START: mod_x = XW'(start_addr);
      default:                  mod_x = XW'(cur);
    endcase
  end

  i2cee_mod #(
    .XW (XW),
    .MW (MW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mod_start),
    .x     (mod_x),
    .m     (eff_m),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // remainders stay below the memory size, so they fit the address width
  assign rem_a    = mod_rem[AW-1:0];
  assign rem_plus = MW'(rem_a) + MW'(1);
  assign rem_next = (rem_plus == eff_m) ? '0 : rem_plus[AW-1:0];
  assign wa_plus  = MW'(wa) + MW'(1);
  assign wa_next  = (wa_plus == eff_m) ? '0 : wa_plus[AW-1:0];
  assign room     = fill < eff_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= '0;
      start_addr <= '0;
      fill       <= '0;
      high       <= '0;
      seen       <= '0;
      pending    <= 1'b0;
      active     <= 1'b0;
      clr_addr   <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.do_match && (tgt == dev_addr)) begin
        active <= 1'b1;
        if (!rnw) begin
          seen <= '0;
        end
      end
      if (cmd.latch_high) begin
        high <= dbyte;
        seen <= 2'd1;
      end
      if (cmd.buffer_byte && room) begin
        fill <= fill + PW'(1);
      end
      if (cmd.addr_set) begin
        cur        <= rem_a;
        start_addr <= rem_a;
        fill       <= '0;
        pending    <= 1'b1;
        seen       <= 2'd2;
      end
      if (cmd.cur_inc || cmd.read_issue) begin
        cur <= rem_next;
      end
      if (cmd.stop_finish) begin
        pending <= 1'b0;
        seen    <= '0;
        active  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_init) begin
      wa  <= rem_a;
      idx <= '0;
    end else if (cmd.commit_write) begin
      wa  <= wa_next;
      idx <= idx + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      res_data  <= '0;
      res_valid <= 1'b0;
    end else if (cmd.capture_read) begin
      res_data  <= mem_rdata;
      res_valid <= 1'b1;
    end
  end

  assign pb_we     = cmd.buffer_byte && room;
  assign mem_we    = cmd.clear_step || cmd.commit_write;
  assign mem_waddr = cmd.clear_step ? clr_addr : wa;
  assign mem_wdata = cmd.clear_step ? i2cee_pkg::ERASED_BYTE : pb_rdata;

  i2cee_ram #(
    .WIDTH (BW),
    .DEPTH (PAGE_DEPTH)
  ) u_page_buf (
    .clk   (clk),
    .we    (pb_we),
    .waddr (fill[PBW-1:0]),
    .wdata (dbyte),
    .raddr (idx[PBW-1:0]),
    .rdata (pb_rdata)
  );

  i2cee_ram #(
    .WIDTH (BW),
    .DEPTH (MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rem_a),
    .rdata (mem_rdata)
  );

  always_comb begin
    status.action        = act;
    status.active        = active;
    status.seen          = seen;
    status.write_pending = pending;
    status.fill_zero     = (fill == '0);
    status.commit_last   = ((idx + PW'(1)) == fill);
    status.mod_done      = mod_done;
    status.clear_last    = (clr_addr == AW'(MEM_DEPTH - 1));
  end

  assign read_data  = res_data;
  assign read_valid = res_valid;
  assign selected   = active;

endmodule

`default_nettype wire

[hdl/i2cee_ctrl.sv]
// Controller state machine: sequences each bus event through the datapath.
`default_nettype none

module i2cee_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire i2cee_pkg::status_t  status,
  output i2cee_pkg::cmd_t          cmd,
  output logic                     busy,
  output logic                     done
);

  i2cee_pkg::state_t state;
  i2cee_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2cee_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.mod_src = i2cee_pkg::MOD_SRC_CUR;
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      i2cee_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = i2cee_pkg::ST_IDLE;
        end
      end
      i2cee_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_item = 1'b1;
          state_next    = i2cee_pkg::ST_DISPATCH;
        end
      end
      i2cee_pkg::ST_DISPATCH: begin
        state_next = i2cee_pkg::ST_DONE;
        unique case (status.action)
          i2cee_pkg::ACT_MATCH: begin
            cmd.do_match = 1'b1;
          end
          i2cee_pkg::ACT_RX: begin
            if (status.active) begin
              if (status.seen == 2'd0) begin
                cmd.latch_high = 1'b1;
              end else if (status.seen == 2'd1) begin
                cmd.mod_start = 1'b1;
                cmd.mod_src   = i2cee_pkg::MOD_SRC_ADDR;
                state_next    = i2cee_pkg::ST_MOD;
              end else begin
                cmd.buffer_byte = 1'b1;
                cmd.mod_start   = 1'b1;
                state_next      = i2cee_pkg::ST_MOD;
              end
            end
          end
          i2cee_pkg::ACT_READ: begin
            if (status.active) begin
              cmd.mod_start = 1'b1;
              state_next    = i2cee_pkg::ST_MOD;
            end
          end
          i2cee_pkg::ACT_STOP: begin
            if (status.active) begin
              if (status.write_pending) begin
                cmd.mod_start = 1'b1;
                cmd.mod_src   = i2cee_pkg::MOD_SRC_START;
                state_next    = i2cee_pkg::ST_MOD;
              end else begin
                cmd.stop_finish = 1'b1;
              end
            end
          end
        endcase
      end
      i2cee_pkg::ST_MOD: begin
        if (status.mod_done) begin
          state_next = i2cee_pkg::ST_APPLY;
        end
      end
      i2cee_pkg::ST_APPLY: begin
        state_next = i2cee_pkg::ST_DONE;
        unique case (status.action)
          i2cee_pkg::ACT_RX: begin
            if (status.seen == 2'd1) begin
              cmd.addr_set = 1'b1;
            end else begin
              cmd.cur_inc = 1'b1;
            end
          end
          i2cee_pkg::ACT_READ: begin
            cmd.read_issue = 1'b1;
            state_next     = i2cee_pkg::ST_RDMEM;
          end
          i2cee_pkg::ACT_STOP: begin
            cmd.commit_init = 1'b1;
            if (status.fill_zero) begin
              cmd.stop_finish = 1'b1;
            end else begin
              state_next = i2cee_pkg::ST_COMMIT_RD;
            end
          end
          i2cee_pkg::ACT_MATCH: begin
            state_next = i2cee_pkg::ST_DONE;
          end
        endcase
      end
      i2cee_pkg::ST_RDMEM: begin
        cmd.capture_read = 1'b1;
        state_next       = i2cee_pkg::ST_DONE;
      end
      i2cee_pkg::ST_COMMIT_RD: begin
        // page buffer read in flight
        state_next = i2cee_pkg::ST_COMMIT_WR;
      end
      i2cee_pkg::ST_COMMIT_WR: begin
        cmd.commit_write = 1'b1;
        if (status.commit_last) begin
          cmd.stop_finish = 1'b1;
          state_next      = i2cee_pkg::ST_DONE;
        end else begin
          state_next = i2cee_pkg::ST_COMMIT_RD;
        end
      end
      i2cee_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = i2cee_pkg::ST_IDLE;
      end
      default: begin
        state_next = i2cee_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/i2c_eeprom_slave_model.sv]
// Top level of the byte-event I2C serial EEPROM slave model.
// Each accepted event passes dispatch; while selected, a second address byte, a data byte, a
//   read and a stop with a page pending also wait on the remainder unit, a read then adds a
//   memory read, and a stop that commits a page runs the commit loop once per buffered byte.
// Throughput: one event at a time; the 16-step remainder unit and the commit loop set it.
// Reset: synchronous; a pass then erases every memory byte, busy high; no result stall.
`default_nettype none

module i2c_eeprom_slave_model #(
  parameter int MEM_DEPTH  = 4096,
  parameter int PAGE_DEPTH = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration write port
  input  wire logic                               cfg_write,
  input  wire logic [i2cee_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [i2cee_pkg::CFG_DATA_W-1:0]   cfg_data,
  // event transfer in
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         action,
  input  wire logic [i2cee_pkg::DEV_ADDR_W-1:0]   target_address,
  input  wire logic                               read_not_write,
  input  wire logic [i2cee_pkg::BYTE_W-1:0]       data_byte,
  // result transfer out, valid for the single cycle done is high
  output logic                                    done,
  output logic      [i2cee_pkg::BYTE_W-1:0]       read_data,
  output logic                                    read_valid,
  output logic                                    selected
);

  i2cee_pkg::cmd_t    cmd;
  i2cee_pkg::status_t status;

  // Controller: owns the event sequencing (dispatch, remainder wait, apply,
  // memory read, page commit sweep, memory clear sweep after reset).
  i2cee_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Datapath: config registers, transaction state, modulo unit for every
  // address reduction, page buffer RAM and the EEPROM array RAM.
  i2cee_dpath #(
    .MEM_DEPTH  (MEM_DEPTH),
    .PAGE_DEPTH (PAGE_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (action),
    .target_address (target_address),
    .read_not_write (read_not_write),
    .data_byte      (data_byte),
    .cmd            (cmd),
    .status         (status),
    .read_data      (read_data),
    .read_valid     (read_valid),
    .selected       (selected)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the byte-event I2C EEPROM slave model.
`default_nettype none

module testbench;
  import i2cee_pkg::*;

  localparam int MEM_DEPTH       = 4096;
  localparam int PAGE_DEPTH      = 64;
  localparam int PERIOD          = 12;
  localparam int RESET_CYCLES    = 9;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int N_DIRECTED      = 27;
  // Worst case per event: committing stop of a full page plus the longest random
  // gap; ~2300 events plus the clearing pass, taken several times over.
  localparam int CYCLE_LIMIT     = 2_000_000;
  // Longest event latency: a stop that commits a full page.
  localparam int SETTLE_CYCLES   = 20 + 2 * PAGE_DEPTH + 20;
  // Index 3 is not decoded; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] rd;
    logic              rv;
    logic              sel;
  } bus_resp_t;

  typedef struct packed {
    action_t               act;
    logic [DEV_ADDR_W-1:0] tgt;
    logic                  rnw;
    logic [BYTE_W-1:0]     dbyte;
    logic                  typed;
    bus_resp_t             resp;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    start = 1'b0;
  logic                    busy;
  action_t                 action = ACT_MATCH;
  logic [DEV_ADDR_W-1:0]   target_address = '0;
  logic                    read_not_write = 1'b0;
  logic [BYTE_W-1:0]       data_byte = '0;
  logic                    done;
  logic [BYTE_W-1:0]       read_data;
  logic                    read_valid;
  logic                    selected;

  i2c_eeprom_slave_model #(
    .MEM_DEPTH (MEM_DEPTH),
    .PAGE_DEPTH(PAGE_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .target_address(target_address),
    .read_not_write(read_not_write),
    .data_byte     (data_byte),
    .done          (done),
    .read_data     (read_data),
    .read_valid    (read_valid),
    .selected      (selected)
  );

  initial begin
    forever #(PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // EEPROM shadow: register copies and slave state, updated per accepted event
  // ---------------------------------------------------------------------------
  logic [DEV_ADDR_W-1:0]  cfg_dev  = DEV_ADDR_RESET;
  logic [MEM_SIZE_W-1:0]  cfg_mem  = MEM_SIZE_RESET;
  logic [PAGE_SIZE_W-1:0] cfg_page = PAGE_SIZE_RESET;

  logic [BYTE_W-1:0] mem_img  [MEM_DEPTH];
  logic [BYTE_W-1:0] page_img [PAGE_DEPTH];
  int unsigned cur_addr, page_start, fill_cnt, high_latch, addr_seen;
  bit          wr_pending, active;

  bus_resp_t   expected_resp [$];   // responses still owed by the DUT
  int unsigned mismatch_count;
  int unsigned live_items;          // events the slave did not simply ignore
  int unsigned cycle_count;
  bit          idle_on;             // random gaps between transfers enabled
  logic [BYTE_W-1:0] last_hi, last_lo;

  // Out-of-range sizes: zero acts as one, anything above the array is the array.
  function automatic int unsigned mem_span();
    if (cfg_mem == 0) return 1;
    if (cfg_mem > MEM_DEPTH) return MEM_DEPTH;
    return cfg_mem;
  endfunction

  // Page limit is clamped to the page buffer and then to the memory in use.
  function automatic int unsigned page_span();
    int unsigned p;
    p = cfg_page;
    if (p == 0) p = 1;
    if (p > PAGE_DEPTH) p = PAGE_DEPTH;
    if (p > mem_span()) p = mem_span();
    return p;
  endfunction

  task automatic apply_event(input action_t act, input logic [DEV_ADDR_W-1:0] tgt,
                             input logic rnw, input logic [BYTE_W-1:0] dbyte,
                             output bus_resp_t r, output bit touched);
    int unsigned span, a;
    span    = mem_span();
    r       = '0;
    touched = active;
    case (act)
      ACT_MATCH: begin
        // Foreign address leaves everything alone. A read-direction match keeps
        // the address phase and a pending page (random read via repeated start).
        if (tgt == cfg_dev) begin
          touched = 1'b1;
          active  = 1'b1;
          if (!rnw) addr_seen = 0;
        end
      end
      ACT_RX: begin
        if (active) begin
          if (addr_seen == 0) begin
            high_latch = dbyte;
            addr_seen  = 1;
          end else if (addr_seen == 1) begin
            cur_addr   = ((high_latch << 8) | dbyte) % span;
            page_start = cur_addr;
            fill_cnt   = 0;
            wr_pending = 1'b1;
            addr_seen  = 2;
          end else begin
            // full page: byte dropped, address still moves on
            if (fill_cnt < page_span()) begin
              page_img[fill_cnt] = dbyte;
              fill_cnt++;
            end
            cur_addr = ((cur_addr % span) + 1) % span;
          end
        end
      end
      ACT_READ: begin
        if (active) begin
          a        = cur_addr % span;
          r.rd     = mem_img[a];
          r.rv     = 1'b1;
          cur_addr = (a + 1) % span;
        end
      end
      ACT_STOP: begin
        if (active) begin
          // a stop after one address byte starts no new page; only an older pending page lands
          if (wr_pending) begin
            for (int i = 0; i < fill_cnt; i++)
              mem_img[(page_start + i) % span] = page_img[i];
            wr_pending = 1'b0;
          end
          addr_seen = 0;
          active    = 1'b0;
        end
      end
    endcase
    r.sel = active;
  endtask

  // ---------------------------------------------------------------------------
  // Event driver. Fields and start change by NBA at a rising edge; the transfer
  // is taken at the first edge where busy, sampled before the edge, is low.
  // With a zero gap start stays high and the next event follows back to back.
  // ---------------------------------------------------------------------------
  task automatic send_event(input action_t act, input logic [DEV_ADDR_W-1:0] tgt,
                            input logic rnw, input logic [BYTE_W-1:0] dbyte,
                            input logic typed, input bus_resp_t typed_resp);
    bus_resp_t   predicted;
    bit          touched;
    int unsigned gap;
    action         <= act;
    target_address <= tgt;
    read_not_write <= rnw;
    data_byte      <= dbyte;
    start          <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    apply_event(act, tgt, rnw, dbyte, predicted, touched);
    expected_resp.push_back(typed ? typed_resp : predicted);
    if (touched) live_items++;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic emit(input action_t act, input logic [DEV_ADDR_W-1:0] tgt,
                      input logic rnw, input logic [BYTE_W-1:0] dbyte);
    send_event(act, tgt, rnw, dbyte, 1'b0, '0);
  endtask

  // Drop start and wait until every owed response is in and the slave is free.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_resp.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // One register write per edge; cfg_write stays up across a burst.
  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_DEVICE_ADDRESS: cfg_dev  = val[DEV_ADDR_W-1:0];
      CFG_MEM_SIZE:       cfg_mem  = val;
      CFG_PAGE_SIZE:      cfg_page = val[PAGE_SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] dev,
                              input logic [CFG_DATA_W-1:0] msize,
                              input logic [CFG_DATA_W-1:0] psize, input bit poke_spare);
    put_reg(CFG_DEVICE_ADDRESS, dev);
    put_reg(CFG_MEM_SIZE, msize);
    put_reg(CFG_PAGE_SIZE, psize);
    if (poke_spare) put_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly well-formed transactions with random content,
  // the rest loose events and broken sequences.
  // ---------------------------------------------------------------------------
  task automatic random_transfer_group();
    int unsigned kind, n;
    logic [BYTE_W-1:0] hi, lo;
    kind = $urandom_range(0, 99);
    hi   = BYTE_W'($urandom);
    lo   = BYTE_W'($urandom);
    if (kind < 35) begin
      // page write; a missing stop leaves the page pending for a repeated start
      emit(ACT_MATCH, cfg_dev, 1'b0, BYTE_W'($urandom));
      emit(ACT_RX, DEV_ADDR_W'($urandom), 1'($urandom), hi);
      emit(ACT_RX, DEV_ADDR_W'($urandom), 1'($urandom), lo);
      last_hi = hi;
      last_lo = lo;
      n = $urandom_range(0, page_span() + 3);
      repeat (n) emit(ACT_RX, DEV_ADDR_W'($urandom), 1'($urandom), BYTE_W'($urandom));
      if ($urandom_range(0, 9) != 0)
        emit(ACT_STOP, DEV_ADDR_W'($urandom), 1'($urandom), BYTE_W'($urandom));
    end else if (kind < 60) begin
      // random read: address write, repeated start in read direction, reads
      if ($urandom_range(0, 1) == 0) begin
        hi = last_hi;
        lo = last_lo;
      end
      emit(ACT_MATCH, cfg_dev, 1'b0, BYTE_W'($urandom));
      emit(ACT_RX, DEV_ADDR_W'($urandom), 1'($urandom), hi);
      emit(ACT_RX, DEV_ADDR_W'($urandom), 1'($urandom), lo);
      emit(ACT_MATCH, cfg_dev, 1'b1, BYTE_W'($urandom));
      repeat ($urandom_range(1, 8))
        emit(ACT_READ, DEV_ADDR_W'($urandom), 1'($urandom), BYTE_W'($urandom));
      emit(ACT_STOP, DEV_ADDR_W'($urandom), 1'($urandom), BYTE_W'($urandom));
    end else if (kind < 75) begin
      // current-address read
      emit(ACT_MATCH, cfg_dev, 1'b1, BYTE_W'($urandom));
      repeat ($urandom_range(1, 8))
        emit(ACT_READ, DEV_ADDR_W'($urandom), 1'($urandom), BYTE_W'($urandom));
      emit(ACT_STOP, DEV_ADDR_W'($urandom), 1'($urandom), BYTE_W'($urandom));
    end else begin
      // loose events: foreign matches, stray bytes/reads/stops, partial addresses
      repeat ($urandom_range(1, 4))
        emit(action_t'($urandom_range(0, 3)),
             ($urandom_range(0, 1) == 0) ? cfg_dev : DEV_ADDR_W'($urandom),
             1'($urandom), BYTE_W'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed events at reset settings. Expected responses are typed in where
  // they are obvious; the rest come from the shadow.
  // ---------------------------------------------------------------------------
  localparam logic [DEV_ADDR_W-1:0] DA = DEV_ADDR_RESET;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ACT_READ,  7'd0,   1'b0, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}}, // read, not selected
    '{ACT_MATCH, 7'd0,   1'b0, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}}, // foreign address
    '{ACT_MATCH, DA,     1'b0, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{ACT_RX,    7'd0,   1'b0, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1}}, // address 0xFFFF wraps
    '{ACT_RX,    7'd0,   1'b0, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{ACT_RX,    7'd0,   1'b0, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}}, // lands on last byte
    '{ACT_RX,    7'd0,   1'b0, 8'hA5, 1'b1, '{8'h00, 1'b0, 1'b1}}, // wraps to byte 0
    '{ACT_STOP,  7'd0,   1'b0, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{ACT_MATCH, DA,     1'b1, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{ACT_READ,  7'd0,   1'b0, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b1}}, // erased byte
    '{ACT_MATCH, DA,     1'b0, 8'h00, 1'b0, '0},
    '{ACT_RX,    7'd0,   1'b0, 8'h0F, 1'b0, '0},
    '{ACT_RX,    7'd0,   1'b0, 8'hFF, 1'b0, '0},
    '{ACT_MATCH, DA,     1'b1, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}}, // repeated start
    '{ACT_READ,  7'd0,   1'b0, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}},
    '{ACT_READ,  7'd0,   1'b0, 8'h00, 1'b1, '{8'hA5, 1'b1, 1'b1}},
    '{ACT_STOP,  7'd0,   1'b0, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}}, // empty page
    '{ACT_RX,    7'd0,   1'b0, 8'h55, 1'b1, '{8'h00, 1'b0, 1'b0}}, // byte, not selected
    '{ACT_MATCH, 7'd127, 1'b1, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}}, // foreign, read
    '{ACT_MATCH, DA,     1'b1, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{ACT_RX,    7'd0,   1'b0, 8'h00, 1'b0, '0},                    // bytes after read match
    '{ACT_RX,    7'd0,   1'b0, 8'h05, 1'b0, '0},
    '{ACT_RX,    7'd0,   1'b0, 8'h3C, 1'b0, '0},
    '{ACT_STOP,  7'd0,   1'b0, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{ACT_MATCH, DA,     1'b0, 8'h00, 1'b0, '0},
    '{ACT_RX,    7'd0,   1'b0, 8'h12, 1'b0, '0},                    // one address byte only
    '{ACT_STOP,  7'd0,   1'b0, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}}
  };

  // ---------------------------------------------------------------------------
  // Response checker: each done strobe is matched with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                 input logic [BYTE_W-1:0] want);
    $display("MISMATCH @%0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    bus_resp_t want;
    if (!rst && done === 1'b1) begin
      if (expected_resp.size() == 0) begin
        report_mismatch("response with no event outstanding, read_data", read_data, 8'h00);
      end else begin
        want = expected_resp.pop_front();
        if (read_data !== want.rd)   report_mismatch("read_data", read_data, want.rd);
        if (read_valid !== want.rv)  report_mismatch("read_valid", read_valid, want.rv);
        if (selected !== want.sel)   report_mismatch("selected", selected, want.sel);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned live_target;
    for (int i = 0; i < MEM_DEPTH; i++) mem_img[i] = ERASED_BYTE;
    for (int i = 0; i < PAGE_DEPTH; i++) page_img[i] = '0;
    idle_on = 1'b1;
    last_hi = '0;
    last_lo = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    // busy covers the post-reset clearing pass of the memory
    drain();

    foreach (directed_rows[i])
      send_event(directed_rows[i].act, directed_rows[i].tgt, directed_rows[i].rnw,
                 directed_rows[i].dbyte, directed_rows[i].typed, directed_rows[i].resp);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // registers only change with nothing in flight; a transaction may still
      // be open, which covers a size change in mid-transaction
      drain();
      case (ph)
        0: program_regs(DEV_ADDR_RESET, MEM_SIZE_RESET, PAGE_SIZE_RESET, 1'b0);
        1: program_regs(13'd0, 13'd1, 13'd1, 1'b0);
        2: program_regs(13'd127, 13'd4096, 13'd64, 1'b1);
        3: program_regs(13'($urandom_range(0, 127)), 13'd0, 13'd0, 1'b0);    // zero sizes
        4: program_regs(13'($urandom_range(0, 127)), 13'h1FFF, 13'h7F, 1'b0); // oversize
        5: program_regs(13'($urandom_range(0, 127)), 13'd16, 13'd64, 1'b0);  // page > mem
        6: program_regs(13'($urandom_range(0, 127)), 13'd100, 13'd7, 1'b0);
        default: program_regs(13'($urandom_range(0, 127)),
                              ($urandom_range(0, 3) == 0) ? 13'd4096
                                                          : 13'($urandom_range(1, 300)),
                              13'($urandom_range(1, 64)), 1'b0);
      endcase
      idle_on     = ($urandom_range(0, 1) == 1);
      live_target = live_items + ITEMS_PER_PHASE;
      while (live_items < live_target) begin
        // alternate stretches with and without gaps
        if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
        random_transfer_group();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
